// ===== hw/rtl/mffc_pkg.sv =====
package mffc_pkg;

  localparam int DEPTH_FRAMES = 1024;
  localparam int MAX_CHANNELS = 8;
  localparam int MIN_CAPACITY = 2;
  localparam int SAMPLE_W     = 32;
  localparam int COUNT_W      = 32;
  localparam int ADDR_W       = $clog2(DEPTH_FRAMES);
  localparam int FILL_W       = $clog2(DEPTH_FRAMES + 1);
  localparam int CH_W         = 4;
  localparam int FUNC_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_W        = FILL_W;

  localparam int IN_TDATA_W   = ((SAMPLE_W * MAX_CHANNELS + 7) / 8) * 8;
  localparam int FILL_LSB     = SAMPLE_W * MAX_CHANNELS;
  localparam int DROP_LSB     = FILL_LSB + FILL_W;
  localparam int UNDER_LSB    = DROP_LSB + COUNT_W;
  localparam int OUT_PAYLOAD_W = UNDER_LSB + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_PAYLOAD_W + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;

  localparam logic [CH_W-1:0]   CH_RESET  = 4'd2;
  localparam logic [FILL_W-1:0] CAP_RESET = FILL_W'(DEPTH_FRAMES);

  typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] sample_vec_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
  } lane_cmd_t;

  typedef struct packed {
    logic               done_ok;
    logic               pop_ok;
    logic [CH_W-1:0]    channels;
    logic [FILL_W-1:0]  fill;
    logic [COUNT_W-1:0] drops;
    logic [COUNT_W-1:0] underruns;
  } status_t;

endpackage

// ===== hw/rtl/multichannel_frame_fifo_core.sv =====
// Channel | Beat fields (low bit up)                             | Accept
// in      | tdata: sample_in_0..7 ; tuser: func                  | in_tvalid & in_tready
// out     | tdata: sample_out_0..7, fill_level, drop_count,      | out_tvalid & out_tready
//         |        underrun_count, pad ; tuser: done_ok          |
// cfg     | index 0 channels_in_use, 1 capacity_frames           | cfg_we
//
// One beat per cycle sustained while out_tready is high; a result passes through
// the registered lane RAM read and then the output register.
// Synchronous active-low reset; no RAM clearing pass, entries are read only
// after being written. A stalled output holds one result plus one in flight,
// then in_tready drops until out_tready returns.
module multichannel_frame_fifo_core
  import mffc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // sample_in_0 .. sample_in_7
  input  logic [FUNC_W-1:0]      in_tuser,   // func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // sample_out_0..7, fill_level,
                                             // drop_count, underrun_count, pad
  output logic                   out_tuser   // done_ok
);

  logic                    s1_valid;
  logic                    s1_ready;
  status_t                 s1_status;
  lane_cmd_t               cmd;
  logic [MAX_CHANNELS-1:0] lane_en;
  sample_vec_t             wdata;
  sample_vec_t             lane_rdata;
  logic                    in_accept;

  assign in_tready = !s1_valid || s1_ready;
  assign in_accept = in_tvalid && in_tready;
  assign wdata     = sample_vec_t'(in_tdata[SAMPLE_W*MAX_CHANNELS-1:0]);

  mffc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .func      (in_tuser),
    .s1_ready  (s1_ready),
    .s1_valid  (s1_valid),
    .s1_status (s1_status),
    .cmd       (cmd),
    .lane_en   (lane_en)
  );

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
    mffc_lane u_lane (
      .clk     (clk),
      .cmd     (cmd),
      .lane_en (lane_en[i]),
      .wdata   (wdata[i]),
      .rdata   (lane_rdata[i])
    );
  end

  mffc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1_status  (s1_status),
    .lane_rdata (lane_rdata),
    .s1_ready   (s1_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/mffc_lane.sv =====
module mffc_lane
  import mffc_pkg::*;
(
  input  logic                clk,
  input  lane_cmd_t           cmd,
  input  logic                lane_en,
  input  logic [SAMPLE_W-1:0] wdata,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH_FRAMES];
  logic [SAMPLE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && lane_en) begin
      mem[cmd.addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/mffc_ctrl.sv =====
module mffc_ctrl
  import mffc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_accept,
  input  logic [FUNC_W-1:0]    func,
  input  logic                 s1_ready,
  output logic                 s1_valid,
  output status_t              s1_status,
  output lane_cmd_t            cmd,
  output logic [MAX_CHANNELS-1:0] lane_en
);

  logic [CH_W-1:0]    channels_r, channels_nxt;
  logic [FILL_W-1:0]  capacity_r, capacity_nxt;
  logic [ADDR_W-1:0]  head_r, head_nxt;
  logic [ADDR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0]  held_r, held_nxt;
  logic [COUNT_W-1:0] drops_r, drops_nxt;
  logic [COUNT_W-1:0] under_r, under_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  status_t            s1_status_r, s1_status_nxt;

  logic [CH_W-1:0]    ch_eff;
  logic [FILL_W-1:0]  cap_eff;
  logic [FILL_W-1:0]  head_inc, tail_inc;
  logic               ok;
  logic               pop_ok;

  always_comb begin
    if (channels_r == '0) begin
      ch_eff = CH_W'(1);
    end else if (channels_r > CH_W'(MAX_CHANNELS)) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = channels_r;
    end
    if (capacity_r < FILL_W'(MIN_CAPACITY)) begin
      cap_eff = FILL_W'(MIN_CAPACITY);
    end else if (capacity_r > FILL_W'(DEPTH_FRAMES)) begin
      cap_eff = FILL_W'(DEPTH_FRAMES);
    end else begin
      cap_eff = capacity_r;
    end
  end

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_en
    assign lane_en[i] = (ch_eff > CH_W'(i));
  end

  assign head_inc = {{(FILL_W-ADDR_W){1'b0}}, head_r} + FILL_W'(1);
  assign tail_inc = {{(FILL_W-ADDR_W){1'b0}}, tail_r} + FILL_W'(1);

  always_comb begin
    channels_nxt  = channels_r;
    capacity_nxt  = capacity_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    held_nxt      = held_r;
    drops_nxt     = drops_r;
    under_nxt     = under_r;
    ok            = 1'b0;
    pop_ok        = 1'b0;
    cmd.wr_en     = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.addr      = tail_r;
    s1_valid_nxt  = s1_valid_r && !s1_ready;
    s1_status_nxt = s1_status_r;

    if (cfg_we && (cfg_index == REG_CHANNELS || cfg_index == REG_CAPACITY)) begin
      if (cfg_index == REG_CHANNELS) begin
        channels_nxt = cfg_wdata[CH_W-1:0];
      end else begin
        capacity_nxt = cfg_wdata;
      end
      head_nxt  = '0;
      tail_nxt  = '0;
      held_nxt  = '0;
      drops_nxt = '0;
      under_nxt = '0;
    end else if (in_accept) begin
      case (func)
        FUNC_PUSH: begin
          if (held_r >= cap_eff) begin
            drops_nxt = (drops_r == '1) ? drops_r : drops_r + COUNT_W'(1);
          end else begin
            cmd.wr_en = 1'b1;
            cmd.addr  = tail_r;
            tail_nxt  = (tail_inc >= cap_eff) ? '0 : tail_inc[ADDR_W-1:0];
            held_nxt  = held_r + FILL_W'(1);
            ok        = 1'b1;
          end
        end
        FUNC_POP: begin
          if (held_r == '0) begin
            under_nxt = (under_r == '1) ? under_r : under_r + COUNT_W'(1);
          end else begin
            cmd.rd_en = 1'b1;
            cmd.addr  = head_r;
            head_nxt  = (head_inc >= cap_eff) ? '0 : head_inc[ADDR_W-1:0];
            held_nxt  = held_r - FILL_W'(1);
            ok        = 1'b1;
            pop_ok    = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          head_nxt  = '0;
          tail_nxt  = '0;
          held_nxt  = '0;
          drops_nxt = '0;
          under_nxt = '0;
        end
        default: begin
        end
      endcase
      s1_valid_nxt            = 1'b1;
      s1_status_nxt.done_ok   = ok;
      s1_status_nxt.pop_ok    = pop_ok;
      s1_status_nxt.channels  = ch_eff;
      s1_status_nxt.fill      = held_nxt;
      s1_status_nxt.drops     = drops_nxt;
      s1_status_nxt.underruns = under_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channels_r <= CH_RESET;
      capacity_r <= CAP_RESET;
      head_r     <= '0;
      tail_r     <= '0;
      held_r     <= '0;
      drops_r    <= '0;
      under_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      channels_r <= channels_nxt;
      capacity_r <= capacity_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      held_r     <= held_nxt;
      drops_r    <= drops_nxt;
      under_r    <= under_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_status_r <= s1_status_nxt;
  end

  assign s1_valid  = s1_valid_r;
  assign s1_status = s1_status_r;

endmodule

// ===== hw/rtl/mffc_merge.sv =====
module mffc_merge
  import mffc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s1_valid,
  input  status_t                s1_status,
  input  sample_vec_t            lane_rdata,
  output logic                   s1_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser
);

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;
  sample_vec_t            samples;

  assign s1_ready = !out_valid_r || out_tready;

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_mask
    assign samples[i] = (s1_status.pop_ok && s1_status.channels > CH_W'(i)) ?
                        lane_rdata[i] : '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (s1_valid && s1_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_TDATA_W'({s1_status.underruns, s1_status.drops,
                                    s1_status.fill, samples});
      out_user_nxt  = s1_status.done_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== hw/rtl/mffc_checker.sv =====
module mffc_checker
  import mffc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // fill never above ring depth
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DROP_LSB-1:FILL_LSB] <= FILL_W'(DEPTH_FRAMES))
    else $error("fill_level above depth");

  // beats without done_ok (failed, clear or unknown func) carry zero samples
  a_zero_samples: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tdata[FILL_LSB-1:0] == '0)
    else $error("samples nonzero without done_ok");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_PAYLOAD_W] == '0)
    else $error("pad bits nonzero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tuser)))
    else $error("stalled beat changed");

endmodule

bind multichannel_frame_fifo_core mffc_checker u_mffc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
